/* rtl/bpc_pkg.sv */
package bpc_pkg;

  // Width of the millisecond clock and of every stored timestamp.
  localparam int unsigned TIME_WIDTH = 32;

  localparam int unsigned DEBOUNCE_WIDTH   = 10;
  localparam int unsigned LONG_PRESS_WIDTH = 16;
  localparam int unsigned AUTO_EXIT_WIDTH  = 20;
  localparam int unsigned CFG_DATA_WIDTH   = AUTO_EXIT_WIDTH;
  localparam int unsigned CFG_INDEX_WIDTH  = 2;

  localparam logic [DEBOUNCE_WIDTH-1:0]   DEBOUNCE_RESET   = DEBOUNCE_WIDTH'(30);
  localparam logic [LONG_PRESS_WIDTH-1:0] LONG_PRESS_RESET = LONG_PRESS_WIDTH'(800);
  localparam logic [AUTO_EXIT_WIDTH-1:0]  AUTO_EXIT_RESET  = AUTO_EXIT_WIDTH'(30000);

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    CfgDebounce  = 2'd0,
    CfgLongPress = 2'd1,
    CfgAutoExit  = 2'd2
  } cfg_index_e;

  typedef enum logic [2:0] {
    ActNone     = 3'd0,
    ActUndo     = 3'd1,
    ActNextPage = 3'd2,
    ActLongExit = 3'd3,
    ActIdleExit = 3'd4,
    ActWake     = 3'd5
  } action_e;

  typedef enum logic {
    OpTick = 1'b0,
    OpEdge = 1'b1
  } opcode_e;

  typedef struct packed {
    logic opcode;
    logic pin_pressed;
    logic log_view_active;
    logic backlight_on;
    logic preparing_sleep;
  } in_req_t;

  typedef struct packed {
    logic [2:0] action;
    logic       backlight_kick;
    logic       speak_exit;
  } out_rsp_t;

endpackage

/* rtl/button_press_classifier_unit.sv */
// Channel   | Direction | Handshake                 | Payload
// ----------+-----------+---------------------------+----------------------------------
// in        | input     | in_valid_i / in_stall_o   | in_req_i  (bpc_pkg::in_req_t)
// out       | output    | out_valid_o / out_stall_i | out_rsp_o (bpc_pkg::out_rsp_t)
// cfg       | input     | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// Every request yields exactly one result: the request waits in the input register,
// then one pass of the classifier logic writes its result into the result register.
// A new request is taken every cycle while in_stall_o is low; the single classifier pass sets this.
// Reset clears the clock, timestamps, flags and both valid bits and loads the register
// defaults (debounce 30 ms, long press 800 ms, idle exit 30000 ms).
// A stall on the result side holds the result register; if the input register is full,
// it holds too and in_stall_o rises in the same cycle. Configuration writes are always ready.
module button_press_classifier_unit (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  bpc_pkg::in_req_t                     in_req_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output bpc_pkg::out_rsp_t                    out_rsp_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [bpc_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index_i,
  input  logic [bpc_pkg::CFG_DATA_WIDTH-1:0]   cfg_data_i
);

  localparam int unsigned TW = bpc_pkg::TIME_WIDTH;

  // Configuration registers.
  logic [bpc_pkg::DEBOUNCE_WIDTH-1:0]   debounce_q;
  logic [bpc_pkg::LONG_PRESS_WIDTH-1:0] long_press_q;
  logic [bpc_pkg::AUTO_EXIT_WIDTH-1:0]  auto_exit_q;

  // Pipeline registers.
  bpc_pkg::in_req_t  in_q;
  logic              in_valid_q;
  bpc_pkg::out_rsp_t out_q, out_d;
  logic              out_valid_q;

  // Classifier state.
  logic [TW-1:0] clock_q, clock_d;
  logic [TW-1:0] last_edge_q, last_edge_d;
  logic [TW-1:0] press_start_q, press_start_d;
  logic [TW-1:0] last_activity_q, last_activity_d;
  logic          prev_log_view_q, prev_log_view_d;
  logic          press_held_q, press_held_d;
  logic          swallow_q, swallow_d;
  logic          exit_spoken_q, exit_spoken_d;
  logic          session_left_q, session_left_d;

  logic out_free;
  logic stage_adv;

  // The result register is free when empty or when its result leaves this cycle.
  // The input register moves on whenever the result register can take its result.
  assign out_free    = !out_valid_q || !out_stall_i;
  assign stage_adv   = in_valid_q && out_free;
  assign in_stall_o  = in_valid_q && !out_free;
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;
  assign cfg_ready_o = 1'b1;

  // Classifier pass. It runs on the request held in the input register and its
  // state update is committed only when the result moves into the result register.
  always_comb begin
    logic          is_edge;
    logic          raw_log;
    logic          lv;
    logic [TW-1:0] since_press;
    logic [TW-1:0] since_activity;
    logic [TW-1:0] since_edge;
    logic          long_reached;

    out_d           = '0;
    clock_d         = clock_q;
    last_edge_d     = last_edge_q;
    press_start_d   = press_start_q;
    last_activity_d = last_activity_q;
    press_held_d    = press_held_q;
    swallow_d       = swallow_q;
    exit_spoken_d   = exit_spoken_q;
    session_left_d  = session_left_q;

    is_edge = (in_q.opcode == bpc_pkg::OpEdge);
    raw_log = in_q.log_view_active;

    // The clock advances on a tick before anything looks at elapsed time.
    if (!is_edge) begin
      clock_d = clock_q + TW'(1);
    end

    // Leaving log view ends the "already left" condition of the session.
    if (!raw_log) begin
      session_left_d = 1'b0;
    end
    lv = raw_log && !session_left_d;

    // Entering log view starts a fresh session.
    if (lv && !prev_log_view_q) begin
      last_activity_d = clock_d;
      press_held_d    = 1'b0;
      exit_spoken_d   = 1'b0;
    end
    prev_log_view_d = lv;

    since_press    = clock_d - press_start_q;
    since_activity = clock_d - last_activity_d;
    since_edge     = clock_d - last_edge_q;
    long_reached   = since_press >= TW'(long_press_q);

    if (!is_edge) begin
      if (lv) begin
        if (press_held_d && long_reached) begin
          out_d.action         = bpc_pkg::ActLongExit;
          out_d.backlight_kick = 1'b1;
          out_d.speak_exit     = !exit_spoken_d;
          exit_spoken_d        = 1'b1;
          press_held_d         = 1'b0;
          last_activity_d      = clock_d;
          session_left_d       = 1'b1;
        end else if (since_activity >= TW'(auto_exit_q)) begin
          // Idle exit is silent and drops any press in progress.
          out_d.action   = bpc_pkg::ActIdleExit;
          press_held_d   = 1'b0;
          swallow_d      = 1'b0;
          session_left_d = 1'b1;
        end
      end
    end else if (since_edge >= TW'(debounce_q)) begin
      last_edge_d = clock_d;
      if (in_q.pin_pressed) begin
        if (!in_q.backlight_on || in_q.preparing_sleep) begin
          // A press on a dark or sleeping screen only wakes it up.
          out_d.action         = bpc_pkg::ActWake;
          out_d.backlight_kick = 1'b1;
          swallow_d            = 1'b1;
          press_held_d         = 1'b0;
        end else if (swallow_q) begin
          swallow_d = 1'b0;
        end else if (!lv) begin
          out_d.action         = bpc_pkg::ActUndo;
          out_d.backlight_kick = 1'b1;
        end else begin
          out_d.backlight_kick = 1'b1;
          press_held_d         = 1'b1;
          press_start_d        = clock_d;
        end
      end else begin
        if (swallow_q) begin
          swallow_d    = 1'b0;
          press_held_d = 1'b0;
        end else if (press_held_d) begin
          press_held_d = 1'b0;
          if (!lv) begin
            out_d.backlight_kick = 1'b1;
          end else if (long_reached) begin
            out_d.action         = bpc_pkg::ActLongExit;
            out_d.backlight_kick = 1'b1;
            out_d.speak_exit     = !exit_spoken_d;
            exit_spoken_d        = 1'b1;
            last_activity_d      = clock_d;
            session_left_d       = 1'b1;
          end else begin
            out_d.action         = bpc_pkg::ActNextPage;
            out_d.backlight_kick = 1'b1;
            last_activity_d      = clock_d;
          end
        end
      end
    end
  end

  // Configuration registers, masked to their widths by the port slices.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q   <= bpc_pkg::DEBOUNCE_RESET;
      long_press_q <= bpc_pkg::LONG_PRESS_RESET;
      auto_exit_q  <= bpc_pkg::AUTO_EXIT_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        bpc_pkg::CfgDebounce:  debounce_q   <= cfg_data_i[bpc_pkg::DEBOUNCE_WIDTH-1:0];
        bpc_pkg::CfgLongPress: long_press_q <= cfg_data_i[bpc_pkg::LONG_PRESS_WIDTH-1:0];
        bpc_pkg::CfgAutoExit:  auto_exit_q  <= cfg_data_i[bpc_pkg::AUTO_EXIT_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // Input register: loads whenever it is empty or its request moves on.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_q <= in_req_i;
    end
  end

  // Result register and classifier state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q     <= 1'b0;
      clock_q         <= '0;
      last_edge_q     <= '0;
      press_start_q   <= '0;
      last_activity_q <= '0;
      prev_log_view_q <= 1'b0;
      press_held_q    <= 1'b0;
      swallow_q       <= 1'b0;
      exit_spoken_q   <= 1'b0;
      session_left_q  <= 1'b0;
    end else begin
      if (out_free) begin
        out_valid_q <= in_valid_q;
      end
      if (stage_adv) begin
        clock_q         <= clock_d;
        last_edge_q     <= last_edge_d;
        press_start_q   <= press_start_d;
        last_activity_q <= last_activity_d;
        prev_log_view_q <= prev_log_view_d;
        press_held_q    <= press_held_d;
        swallow_q       <= swallow_d;
        exit_spoken_q   <= exit_spoken_d;
        session_left_q  <= session_left_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (stage_adv) begin
      out_q <= out_d;
    end
  end

endmodule

/* sim/tb_button_press_classifier_unit.sv */
`timescale 1ns / 1ps

module tb_button_press_classifier_unit;

  // Generous bound on the whole run. Even with every request waiting out the
  // longest sender gap and the longest result stall, a correct run stays far
  // below this.
  localparam int CYCLE_LIMIT = 1_000_000;

  // The register index that maps to no register. Writes to it must be ignored.
  localparam logic [bpc_pkg::CFG_INDEX_WIDTH-1:0] CfgUnused = 2'd3;

  typedef logic [bpc_pkg::CFG_DATA_WIDTH-1:0] cfg_data_t;

  // One row of the directed table: either a register write or a request,
  // optionally with its result typed in by hand.
  typedef struct packed {
    logic                                is_cfg;
    logic [bpc_pkg::CFG_INDEX_WIDTH-1:0] reg_idx;
    logic [bpc_pkg::CFG_DATA_WIDTH-1:0]  reg_data;
    bpc_pkg::in_req_t                    req;
    logic                                typed;
    bpc_pkg::out_rsp_t                   rsp;
  } plan_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  bpc_pkg::in_req_t  in_req_i = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  bpc_pkg::out_rsp_t out_rsp_o;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  logic [bpc_pkg::CFG_INDEX_WIDTH-1:0] cfg_index_i = '0;
  logic [bpc_pkg::CFG_DATA_WIDTH-1:0]  cfg_data_i = '0;

  button_press_classifier_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_rsp_o   (out_rsp_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // Results the classifier owes us, oldest first.
  bpc_pkg::out_rsp_t due_rsp[$];
  bpc_pkg::out_rsp_t oldest;
  int       mismatch_count = 0;
  int       rsp_count = 0;
  int       sent = 0;
  int       cycle_count = 0;
  int       stall_left = 0;
  int       stall_len;
  bit       quiet = 1'b0;

  // Shadow copy of the classifier: register values and timing state.
  logic [bpc_pkg::DEBOUNCE_WIDTH-1:0]   dbnc_ms;
  logic [bpc_pkg::LONG_PRESS_WIDTH-1:0] hold_ms;
  logic [bpc_pkg::AUTO_EXIT_WIDTH-1:0]  idle_ms;
  logic [bpc_pkg::TIME_WIDTH-1:0]       ms_now;
  logic [bpc_pkg::TIME_WIDTH-1:0]       edge_stamp;
  logic [bpc_pkg::TIME_WIDTH-1:0]       press_stamp;
  logic [bpc_pkg::TIME_WIDTH-1:0]       activity_stamp;
  logic log_shown_q;
  logic holding;
  logic eat_release;
  logic exit_announced;
  logic log_abandoned;

  // Milliseconds since a stamp; wraps with the clock width like the hardware.
  function automatic logic [bpc_pkg::TIME_WIDTH-1:0] elapsed(
      input logic [bpc_pkg::TIME_WIDTH-1:0] stamp);
    return ms_now - stamp;
  endfunction

  // A long press leaves the log view. Only the first exit of a session is
  // announced.
  function automatic void take_long_exit(inout bpc_pkg::out_rsp_t rsp);
    rsp.action = bpc_pkg::ActLongExit;
    rsp.backlight_kick = 1'b1;
    if (!exit_announced) begin
      rsp.speak_exit = 1'b1;
      exit_announced = 1'b1;
    end
    holding = 1'b0;
    activity_stamp = ms_now;
    log_abandoned = 1'b1;
  endfunction

  // Advances the shadow state by one accepted request and returns the result
  // the classifier must produce for it.
  function automatic bpc_pkg::out_rsp_t classify_press(input bpc_pkg::in_req_t req);
    bpc_pkg::out_rsp_t              rsp;
    logic                           shown;
    logic [bpc_pkg::TIME_WIDTH-1:0] held;
    rsp = '0;
    if (req.opcode == bpc_pkg::OpTick) ms_now = ms_now + 1'b1;

    // The log view only counts while its flag is up and no exit has been
    // taken since the flag last rose.
    if (!req.log_view_active) log_abandoned = 1'b0;
    shown = req.log_view_active && !log_abandoned;
    if (shown && !log_shown_q) begin
      activity_stamp = ms_now;
      holding = 1'b0;
      exit_announced = 1'b0;
    end
    log_shown_q = shown;

    if (req.opcode == bpc_pkg::OpTick) begin
      if (shown) begin
        if (holding && elapsed(press_stamp) >= hold_ms) begin
          take_long_exit(rsp);
        end else if (elapsed(activity_stamp) >= idle_ms) begin
          rsp.action = bpc_pkg::ActIdleExit;
          holding = 1'b0;
          eat_release = 1'b0;
          log_abandoned = 1'b1;
        end
      end
    end else if (elapsed(edge_stamp) >= dbnc_ms) begin
      edge_stamp = ms_now;
      if (req.pin_pressed) begin
        if (!req.backlight_on || req.preparing_sleep) begin
          rsp.action = bpc_pkg::ActWake;
          rsp.backlight_kick = 1'b1;
          eat_release = 1'b1;
          holding = 1'b0;
        end else if (eat_release) begin
          eat_release = 1'b0;
        end else if (!shown) begin
          rsp.action = bpc_pkg::ActUndo;
          rsp.backlight_kick = 1'b1;
        end else begin
          rsp.backlight_kick = 1'b1;
          holding = 1'b1;
          press_stamp = ms_now;
        end
      end else if (eat_release) begin
        eat_release = 1'b0;
        holding = 1'b0;
      end else if (holding) begin
        held = elapsed(press_stamp);
        holding = 1'b0;
        if (!shown) begin
          // The view was left while the button was down.
          rsp.backlight_kick = 1'b1;
        end else if (held >= hold_ms) begin
          take_long_exit(rsp);
        end else begin
          rsp.action = bpc_pkg::ActNextPage;
          rsp.backlight_kick = 1'b1;
          activity_stamp = ms_now;
        end
      end
    end
    return rsp;
  endfunction

  function automatic bpc_pkg::in_req_t pack_req(input bpc_pkg::opcode_e op, input logic pin,
                                                input logic lv, input logic lit,
                                                input logic slp);
    bpc_pkg::in_req_t r;
    r.opcode = op;
    r.pin_pressed = pin;
    r.log_view_active = lv;
    r.backlight_on = lit;
    r.preparing_sleep = slp;
    return r;
  endfunction

  function automatic plan_t req_row(input bpc_pkg::opcode_e op, input logic pin, input logic lv,
                                    input logic lit, input logic slp);
    plan_t p;
    p = '0;
    p.req = pack_req(op, pin, lv, lit, slp);
    return p;
  endfunction

  function automatic plan_t checked(input plan_t p, input bpc_pkg::action_e act,
                                    input logic kick, input logic spk);
    p.typed = 1'b1;
    p.rsp.action = act;
    p.rsp.backlight_kick = kick;
    p.rsp.speak_exit = spk;
    return p;
  endfunction

  function automatic plan_t cfg_row(input bpc_pkg::cfg_index_e idx,
                                    input logic [bpc_pkg::CFG_DATA_WIDTH-1:0] data);
    plan_t p;
    p = '0;
    p.is_cfg = 1'b1;
    p.reg_idx = idx;
    p.reg_data = data;
    return p;
  endfunction

  // Idle length for either side: mostly none, sometimes short, rarely long.
  function automatic int draw_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Length of a tick run or a held press, scaled to the current register so
  // that timeouts are actually reached when the register is small.
  function automatic int span(input int unsigned limit);
    return (limit > 24) ? 26 : limit + 2;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatch_count++;
    if (mismatch_count <= 40) begin
      $display("result %0d: %s is %0d, expected %0d", rsp_count, what, got, want);
    end
  endtask

  // Offers one request after a random gap and holds it until it is taken.
  // The expected result is recorded at the edge of acceptance.
  task automatic send_request(input bpc_pkg::in_req_t req, input logic typed,
                              input bpc_pkg::out_rsp_t typed_rsp);
    int                gap;
    bpc_pkg::out_rsp_t guess;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i <= req;
    do @(posedge clk_i); while (in_stall_o);
    guess = classify_press(req);
    due_rsp.push_back(typed ? typed_rsp : guess);
    sent++;
  endtask

  // Stops offering requests until every owed result has come back.
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (due_rsp.size() != 0);
  endtask

  // One register write. The channel is lowered for a cycle afterwards so that
  // back-to-back writes never assign the valid twice in one step.
  task automatic write_reg(input logic [bpc_pkg::CFG_INDEX_WIDTH-1:0] idx,
                           input logic [bpc_pkg::CFG_DATA_WIDTH-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      bpc_pkg::CfgDebounce:  dbnc_ms = data[bpc_pkg::DEBOUNCE_WIDTH-1:0];
      bpc_pkg::CfgLongPress: hold_ms = data[bpc_pkg::LONG_PRESS_WIDTH-1:0];
      bpc_pkg::CfgAutoExit:  idle_ms = data[bpc_pkg::AUTO_EXIT_WIDTH-1:0];
      default: ;
    endcase
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Result side: random stall bursts, with quiet stretches when asked.
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else begin
      stall_len = draw_gap();
      out_stall_i <= (stall_len != 0);
      stall_left <= stall_len;
    end
  end

  // Every taken result is checked field by field against the oldest owed one.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (due_rsp.size() == 0) begin
        report_mismatch("result with nothing owed, action", out_rsp_o.action, 0);
      end else begin
        oldest = due_rsp.pop_front();
        if (out_rsp_o.action !== oldest.action)
          report_mismatch("action", out_rsp_o.action, oldest.action);
        if (out_rsp_o.backlight_kick !== oldest.backlight_kick)
          report_mismatch("backlight_kick", out_rsp_o.backlight_kick, oldest.backlight_kick);
        if (out_rsp_o.speak_exit !== oldest.speak_exit)
          report_mismatch("speak_exit", out_rsp_o.speak_exit, oldest.speak_exit);
      end
      rsp_count++;
    end
  end

  // Watchdog: a hang anywhere ends the run as a failure.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("button_press_classifier_unit regression: fail");
      $finish;
    end
  end

  initial begin
    plan_t plan[$];
    logic [bpc_pkg::CFG_DATA_WIDTH-1:0] d;
    logic [bpc_pkg::CFG_DATA_WIDTH-1:0] l;
    logic [bpc_pkg::CFG_DATA_WIDTH-1:0] a;
    logic log_flag;
    logic lit;
    logic doze;
    int   phase_end;
    int   pick;
    int   n;

    // The shadow starts from the reset defaults.
    dbnc_ms = bpc_pkg::DEBOUNCE_RESET;
    hold_ms = bpc_pkg::LONG_PRESS_RESET;
    idle_ms = bpc_pkg::AUTO_EXIT_RESET;
    ms_now = '0;
    edge_stamp = '0;
    press_stamp = '0;
    activity_stamp = '0;
    log_shown_q = 1'b0;
    holding = 1'b0;
    eat_release = 1'b0;
    exit_announced = 1'b0;
    log_abandoned = 1'b0;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed walk. The first edge lands inside the debounce window that
    // reset leaves, so it is dropped. Then debounce goes to zero and short
    // timeouts let every action show up within a few requests.
    plan.push_back(checked(req_row(bpc_pkg::OpEdge, 1, 0, 1, 0), bpc_pkg::ActNone, 0, 0));
    plan.push_back(cfg_row(bpc_pkg::CfgDebounce, 0));
    plan.push_back(cfg_row(bpc_pkg::CfgLongPress, 2));
    plan.push_back(cfg_row(bpc_pkg::CfgAutoExit, 4));
    plan.push_back(checked(req_row(bpc_pkg::OpEdge, 1, 0, 1, 0), bpc_pkg::ActUndo, 1, 0));
    // A dark screen and a pending sleep each turn a press into a wake.
    plan.push_back(checked(req_row(bpc_pkg::OpEdge, 1, 0, 0, 0), bpc_pkg::ActWake, 1, 0));
    plan.push_back(checked(req_row(bpc_pkg::OpEdge, 1, 0, 1, 1), bpc_pkg::ActWake, 1, 0));
    // A stray press while a release is being swallowed, then a release with
    // no timed press behind it.
    plan.push_back(req_row(bpc_pkg::OpEdge, 1, 0, 1, 0));
    plan.push_back(req_row(bpc_pkg::OpEdge, 0, 0, 1, 0));
    // Into the log view: short press gives next page, held press gives the
    // announced long exit on a tick, after which the view counts as left.
    plan.push_back(req_row(bpc_pkg::OpTick, 0, 1, 1, 0));
    plan.push_back(req_row(bpc_pkg::OpEdge, 1, 1, 1, 0));
    plan.push_back(req_row(bpc_pkg::OpEdge, 0, 1, 1, 0));
    plan.push_back(req_row(bpc_pkg::OpEdge, 1, 1, 1, 0));
    plan.push_back(req_row(bpc_pkg::OpTick, 1, 1, 1, 0));
    plan.push_back(req_row(bpc_pkg::OpTick, 1, 1, 1, 0));
    plan.push_back(req_row(bpc_pkg::OpTick, 0, 1, 1, 0));
    // Flag falls and rises again; a press is then released after the view
    // was dropped, which only kicks the backlight.
    plan.push_back(req_row(bpc_pkg::OpTick, 0, 0, 1, 0));
    plan.push_back(req_row(bpc_pkg::OpTick, 0, 1, 1, 0));
    plan.push_back(req_row(bpc_pkg::OpEdge, 1, 1, 1, 0));
    plan.push_back(req_row(bpc_pkg::OpEdge, 0, 0, 1, 0));
    // Back in the log view and left alone until the silent idle exit.
    plan.push_back(req_row(bpc_pkg::OpTick, 0, 1, 1, 0));
    repeat (4) plan.push_back(req_row(bpc_pkg::OpTick, 0, 1, 1, 0));

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        drain();
        write_reg(plan[i].reg_idx, plan[i].reg_data);
      end else begin
        send_request(plan[i].req, plan[i].typed, plan[i].rsp);
      end
    end

    // Random phases, each with its own register setting. The first three are
    // the extremes: zero timeouts, all-ones data that must be masked, and large
    // in-range values. Every fourth phase runs without idling.
    log_flag = 1'b0;
    for (int phase = 0; phase < 12; phase++) begin
      drain();
      case (phase)
        0: begin
          d = '0; l = '0; a = '0;
        end
        1: begin
          d = '1; l = '1; a = '1;
        end
        2: begin
          d = 1000; l = 65535; a = 1000000;
        end
        3: begin
          d = 0; l = 1; a = 1;
        end
        default: begin
          d = cfg_data_t'($urandom_range(0, 4));
          l = cfg_data_t'($urandom_range(1, 12));
          a = cfg_data_t'($urandom_range(2, 40));
        end
      endcase
      write_reg(bpc_pkg::CfgDebounce, d);
      write_reg(bpc_pkg::CfgLongPress, l);
      write_reg(bpc_pkg::CfgAutoExit, a);
      if (phase == 5) write_reg(CfgUnused, cfg_data_t'($urandom));
      quiet = (phase % 4 == 3);
      // A huge debounce drops nearly every edge, so those phases stay short.
      phase_end = sent + ((dbnc_ms > 100) ? 60 : 170);

      while (sent < phase_end) begin
        if ($urandom_range(0, 9) == 0) log_flag = !log_flag;
        lit = ($urandom_range(0, 11) != 0);
        doze = ($urandom_range(0, 11) == 0);
        pick = $urandom_range(0, 99);
        if (pick < 50) begin
          // A press, a hold of some ticks, and a release. Now and then the
          // log flag drops while the button is down.
          send_request(pack_req(bpc_pkg::OpEdge, 1, log_flag, lit, doze), 1'b0, '0);
          n = $urandom_range(0, span(hold_ms));
          repeat (n) send_request(pack_req(bpc_pkg::OpTick, 1'($urandom_range(0, 1)),
                                           log_flag, lit, doze), 1'b0, '0);
          if ($urandom_range(0, 7) == 0) log_flag = !log_flag;
          send_request(pack_req(bpc_pkg::OpEdge, 0, log_flag, lit, doze), 1'b0, '0);
        end else if (pick < 85) begin
          n = $urandom_range(1, span(idle_ms));
          repeat (n) send_request(pack_req(bpc_pkg::OpTick, 1'($urandom_range(0, 1)),
                                           log_flag, lit, doze), 1'b0, '0);
        end else begin
          send_request(bpc_pkg::in_req_t'(5'($urandom_range(0, 31))), 1'b0, '0);
        end
      end
    end

    drain();
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("button_press_classifier_unit regression: pass");
    end else begin
      $display("button_press_classifier_unit regression: fail");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/bpc_pkg.sv
rtl/button_press_classifier_unit.sv
sim/tb_button_press_classifier_unit.sv
